// ===== design/i2c_master_byte_sequencer_top_assert.svh =====
// Assertion macros for the I2C master byte sequencer.
// Included by the top level; needs no other file.
`ifndef I2C_MASTER_BYTE_SEQUENCER_TOP_ASSERT_SVH
`define I2C_MASTER_BYTE_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define I2CMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("i2cms assertion failed");

// Next-cycle implication, checked outside reset.
`define I2CMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("i2cms assertion failed");

`endif

// ===== design/i2cms_pkg.sv =====
// Shared types and constants of the I2C master byte sequencer.
// Used by i2cms_core and the top level; depends on nothing.
`timescale 1ns / 1ps

package i2cms_pkg;

	localparam int unsigned DelayW = 8;
	localparam int unsigned ByteW  = 8;

	localparam logic [DelayW-1:0] ShortDelayRst = 8'd2;
	localparam logic [DelayW-1:0] LongDelayRst  = 8'd5;

	// Command codes carried in the kind field.
	typedef enum logic [2:0] {
		KIND_TICK  = 3'd0,
		KIND_START = 3'd1,
		KIND_STOP  = 3'd2,
		KIND_WRITE = 3'd3,
		KIND_READ  = 3'd4
	} kind_t;

	// Configuration register indexes.
	localparam logic CFG_SHORT_DELAY = 1'b0;
	localparam logic CFG_LONG_DELAY  = 1'b1;

	// One result of a step.
	typedef struct packed {
		logic             ack_bit;
		logic [ByteW-1:0] read_data;
		logic             rejected;
		logic             done_res;
		logic             busy_res;
		logic             sda_level;
		logic             scl_level;
	} res_t;

endpackage

// ===== design/i2cms_core.sv =====
// Sequencer state and its one-step next-state logic.
// Depends on i2cms_pkg.
`timescale 1ns / 1ps

module i2cms_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  logic [2:0]                       kind,
	input  logic [i2cms_pkg::ByteW-1:0]      write_byte,
	input  logic                             send_nack,
	input  logic                             sda_in,
	input  logic [i2cms_pkg::DelayW-1:0]     short_delay,
	input  logic [i2cms_pkg::DelayW-1:0]     long_delay,
	output i2cms_pkg::res_t                  res
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_ST1, PH_ST2, PH_SP1, PH_SP2, PH_SP3, PH_WR1, PH_WR2,
		PH_WR3, PH_AK1, PH_AK2, PH_RD1, PH_RD2, PH_NK1, PH_NK2
	} phase_t;

	phase_t                          phase_q, phase_n;
	logic [3:0]                      bit_count_q, bit_count_n, bit_inc;
	logic [i2cms_pkg::ByteW-1:0]     shifter_q, shifter_n, shift_up;
	logic [i2cms_pkg::DelayW-1:0]    wait_q, wait_n;
	logic                            scl_q, scl_n, sda_q, sda_n;
	logic                            ack_q, ack_n, nack_q, nack_n;
	logic [i2cms_pkg::ByteW-1:0]     rx_q, rx_n;
	logic                            is_cmd, done, rej;

	assign bit_inc  = bit_count_q + 4'd1;
	assign shift_up = {shifter_q[i2cms_pkg::ByteW-2:0], 1'b0};
	assign is_cmd   = (kind == i2cms_pkg::KIND_START) || (kind == i2cms_pkg::KIND_STOP) ||
		(kind == i2cms_pkg::KIND_WRITE) || (kind == i2cms_pkg::KIND_READ);

	always_comb begin
		phase_n     = phase_q;
		bit_count_n = bit_count_q;
		shifter_n   = shifter_q;
		wait_n      = wait_q;
		scl_n       = scl_q;
		sda_n       = sda_q;
		ack_n       = ack_q;
		nack_n      = nack_q;
		rx_n        = rx_q;
		done        = 1'b0;
		rej         = 1'b0;
		if (phase_q != PH_IDLE) begin
			// A command that arrives mid-sequence still counts as one tick.
			rej = is_cmd;
			if (wait_q > 8'd1) begin
				wait_n = wait_q - 8'd1;
			end else begin
				wait_n = '0;
				case (phase_q)
					PH_ST1: begin
						sda_n = 1'b0; phase_n = PH_ST2; wait_n = long_delay;
					end
					PH_ST2: begin
						scl_n = 1'b0; phase_n = PH_IDLE; done = 1'b1;
					end
					PH_SP1: begin
						scl_n = 1'b1; phase_n = PH_SP2; wait_n = long_delay;
					end
					PH_SP2: begin
						sda_n = 1'b1; phase_n = PH_SP3; wait_n = long_delay;
					end
					PH_SP3: begin
						phase_n = PH_IDLE; done = 1'b1;
					end
					PH_WR1: begin
						scl_n = 1'b1; phase_n = PH_WR2; wait_n = long_delay;
					end
					PH_WR2: begin
						scl_n = 1'b0; phase_n = PH_WR3; wait_n = short_delay;
					end
					PH_WR3: begin
						shifter_n   = shift_up;
						bit_count_n = bit_inc;
						wait_n      = short_delay;
						if (bit_inc < 4'd8) begin
							sda_n   = shift_up[i2cms_pkg::ByteW-1];
							phase_n = PH_WR1;
						end else begin
							sda_n   = 1'b1;
							phase_n = PH_AK1;
						end
					end
					PH_AK1: begin
						scl_n = 1'b1; phase_n = PH_AK2; wait_n = long_delay;
					end
					PH_AK2: begin
						ack_n = sda_in; scl_n = 1'b0; phase_n = PH_IDLE; done = 1'b1;
					end
					PH_RD1: begin
						shifter_n = {shifter_q[i2cms_pkg::ByteW-2:0], sda_in};
						scl_n     = 1'b0;
						phase_n   = PH_RD2;
						wait_n    = short_delay;
					end
					PH_RD2: begin
						bit_count_n = bit_inc;
						if (bit_inc < 4'd8) begin
							scl_n   = 1'b1;
							phase_n = PH_RD1;
							wait_n  = long_delay;
						end else begin
							sda_n   = nack_q;
							phase_n = PH_NK1;
							wait_n  = short_delay;
						end
					end
					PH_NK1: begin
						scl_n = 1'b1; phase_n = PH_NK2; wait_n = long_delay;
					end
					PH_NK2: begin
						scl_n   = 1'b0;
						sda_n   = 1'b1;
						rx_n    = shifter_q;
						phase_n = PH_IDLE;
						done    = 1'b1;
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase
			end
		end else if (is_cmd) begin
			case (kind)
				i2cms_pkg::KIND_START: begin
					sda_n = 1'b1; scl_n = 1'b1; phase_n = PH_ST1; wait_n = long_delay;
				end
				i2cms_pkg::KIND_STOP: begin
					sda_n = 1'b0; scl_n = 1'b0; phase_n = PH_SP1; wait_n = long_delay;
				end
				i2cms_pkg::KIND_WRITE: begin
					shifter_n   = write_byte;
					bit_count_n = '0;
					sda_n       = write_byte[i2cms_pkg::ByteW-1];
					phase_n     = PH_WR1;
					wait_n      = short_delay;
				end
				default: begin
					nack_n      = send_nack;
					shifter_n   = '0;
					bit_count_n = '0;
					sda_n       = 1'b1;
					scl_n       = 1'b1;
					phase_n     = PH_RD1;
					wait_n      = long_delay;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_count_q <= '0;
			shifter_q   <= '0;
			wait_q      <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			ack_q       <= 1'b0;
			nack_q      <= 1'b0;
			rx_q        <= '0;
		end else if (step) begin
			phase_q     <= phase_n;
			bit_count_q <= bit_count_n;
			shifter_q   <= shifter_n;
			wait_q      <= wait_n;
			scl_q       <= scl_n;
			sda_q       <= sda_n;
			ack_q       <= ack_n;
			nack_q      <= nack_n;
			rx_q        <= rx_n;
		end
	end

	always_comb begin
		res.scl_level = scl_n;
		res.sda_level = sda_n;
		res.busy_res  = (phase_n != PH_IDLE);
		res.done_res  = done;
		res.rejected  = rej;
		res.read_data = rx_n;
		res.ack_bit   = ack_n;
	end

endmodule

// ===== design/i2c_master_byte_sequencer_top.sv =====
// Top level of the I2C master byte sequencer: input register, config
// registers and result register around i2cms_core. Depends on i2cms_pkg.
//
//   channel   signals                      beat contents
//   s_axis    tvalid tready tdata tuser    tick or command, with SDA sample
//   m_axis    tvalid tready tdata          pin levels and status per tick
//   cfg       cfg_we cfg_index cfg_data    short_delay, long_delay
//
// One beat in and one beat out per tick, one beat per cycle sustained while
// m_axis_tready allows. A beat passes the input register, then the state
// step that loads the result register. The input side keeps taking beats
// while a result waits, until both registers hold data. Reset sets SCL and
// SDA released, the sequencer idle and the delays to 2 and 5 ticks.
`timescale 1ns / 1ps
`include "i2c_master_byte_sequencer_top_assert.svh"

module i2c_master_byte_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // write_byte[7:0], send_nack[8], sda_in[9], zero pad
	input  logic [2:0]  s_axis_tuser,  // kind[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // scl_level, sda_level, busy_res, done_res, rejected,
	                                   // read_data[12:5], ack_bit[13], zero pad
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	logic                              s1_valid_q;
	logic [2:0]                        kind_s1;
	logic [i2cms_pkg::ByteW-1:0]       write_byte_s1;
	logic                              send_nack_s1, sda_in_s1;
	logic                              out_valid_q;
	i2cms_pkg::res_t                   res_c, res_q;
	logic [i2cms_pkg::DelayW-1:0]      short_delay_q, long_delay_q;
	logic                              advance;

	assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_delay_q <= i2cms_pkg::ShortDelayRst;
			long_delay_q  <= i2cms_pkg::LongDelayRst;
		end else if (cfg_we) begin
			if (cfg_index == i2cms_pkg::CFG_SHORT_DELAY) begin
				short_delay_q <= cfg_data;
			end else begin
				long_delay_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1       <= s_axis_tuser;
			write_byte_s1 <= s_axis_tdata[7:0];
			send_nack_s1  <= s_axis_tdata[8];
			sda_in_s1     <= s_axis_tdata[9];
		end
	end

	i2cms_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.kind        (kind_s1),
		.write_byte  (write_byte_s1),
		.send_nack   (send_nack_s1),
		.sda_in      (sda_in_s1),
		.short_delay (short_delay_q),
		.long_delay  (long_delay_q),
		.res         (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, res_q.ack_bit, res_q.read_data, res_q.rejected,
		res_q.done_res, res_q.busy_res, res_q.sda_level, res_q.scl_level};

	// A finished command leaves the sequencer idle.
	`I2CMS_ASSERT_IMPLY(a_done_idle, clk, arst_n, m_axis_tvalid && res_q.done_res,
		!res_q.busy_res)
	// The input side only stalls when the result register is full and blocked.
	`I2CMS_ASSERT_IMPLY(a_stall_cause, clk, arst_n, !s_axis_tready,
		m_axis_tvalid && !m_axis_tready)
	// A registered beat that cannot move on stays put.
	`I2CMS_ASSERT_NEXT(a_s1_kept, clk, arst_n, s1_valid_q && !advance, s1_valid_q)

endmodule
